// ===== src/pisc_pkg.sv =====
`timescale 1ns / 1ps

package pisc_pkg;

    // field widths
    localparam int CH_W       = 3;
    localparam int ANGLE_W    = 31;
    localparam int ERR_W      = ANGLE_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int SUM_W      = 17;
    localparam int DRIVE_W    = 16;
    localparam int SHIFT      = 8;

    // product and sum widths
    localparam int PROD_P_W   = GAIN_W + ERR_W;
    localparam int PROD_I_W   = GAIN_W + SUM_W;
    localparam int PROD_D_W   = GAIN_W + DIFF_W;
    localparam int TOTAL_W    = PROD_D_W + 2;
    localparam int SHIFTED_W  = TOTAL_W - SHIFT;

    // stream words
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIM_W-1:0] INT_LIM_RESET = 15'd2000;
    localparam logic [LIM_W-1:0] SEP_THR_RESET = 15'd200;
    localparam logic [LIM_W-1:0] OUT_LIM_RESET = 15'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_INT_LIM = 3'd3,
        CFG_SEP_THR = 3'd4,
        CFG_OUT_LIM = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         int_lim;
        logic [LIM_W-1:0]         sep_thr;
        logic [LIM_W-1:0]         out_lim;
    } t_cfg;

    // word leaving the state stage
    typedef struct packed {
        logic                     vld;
        logic                     zero;
        logic [CH_W-1:0]          ch;
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  acc;
        logic signed [DIFF_W-1:0] diff;
    } t_err_word;

    // word leaving the multiply stage
    typedef struct packed {
        logic                       vld;
        logic                       zero;
        logic [CH_W-1:0]            ch;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } t_prod_word;

endpackage

// ===== src/pisc_state.sv =====
`timescale 1ns / 1ps

module pisc_state #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic                            i_clr,
    input  logic [pisc_pkg::CH_W-1:0]       i_ch,
    input  logic [pisc_pkg::ANGLE_W-1:0]    i_tgt,
    input  logic [pisc_pkg::ANGLE_W-1:0]    i_meas,
    input  pisc_pkg::t_cfg                  i_cfg,
    output pisc_pkg::t_err_word             o_word
);
    import pisc_pkg::*;

    localparam int MAX_CH = 1 << CH_W;
    localparam int DEPTH  = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // input register
    logic                 r_vld;
    logic                 r_clr;
    logic [CH_W-1:0]      r_ch;
    logic [ANGLE_W-1:0]   r_tgt;
    logic [ANGLE_W-1:0]   r_meas;

    // per-channel state
    logic signed [SUM_W-1:0] r_err_sum  [DEPTH];
    logic signed [ERR_W-1:0] r_prev_err [DEPTH];

    logic                     in_range;
    logic [IDX_W-1:0]         idx;
    logic signed [ERR_W-1:0]  n_err;
    logic [ERR_W-1:0]         mag;
    logic                     integ;
    logic signed [SUM_W:0]    acc_raw;
    logic signed [SUM_W:0]    lim_pos;
    logic signed [SUM_W:0]    lim_neg;
    logic signed [SUM_W-1:0]  n_acc;
    logic signed [DIFF_W-1:0] n_diff;
    t_err_word                r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_clr  <= i_clr;
            r_ch   <= i_ch;
            r_tgt  <= i_tgt;
            r_meas <= i_meas;
        end
    end

    assign in_range = 32'(r_ch) < NUM_CHANNELS;
    assign idx      = r_ch[IDX_W-1:0];

    // error and its magnitude
    assign n_err = $signed({r_tgt[ANGLE_W-1], r_tgt}) - $signed({r_meas[ANGLE_W-1], r_meas});
    assign mag   = n_err[ERR_W-1] ? (~n_err + 1'b1) : n_err;
    assign integ = mag <= {{(ERR_W-LIM_W){1'b0}}, i_cfg.sep_thr};

    // integrate when close to target; error then fits the narrow adder
    assign acc_raw = $signed({r_err_sum[idx][SUM_W-1], r_err_sum[idx]})
                   + (integ ? $signed(n_err[SUM_W:0]) : $signed({(SUM_W+1){1'b0}}));
    assign lim_pos = $signed({{(SUM_W+1-LIM_W){1'b0}}, i_cfg.int_lim});
    assign lim_neg = -lim_pos;

    // clamp the integral
    always_comb begin
        if (acc_raw > lim_pos) begin
            n_acc = lim_pos[SUM_W-1:0];
        end else if (acc_raw < lim_neg) begin
            n_acc = lim_neg[SUM_W-1:0];
        end else begin
            n_acc = acc_raw[SUM_W-1:0];
        end
    end

    assign n_diff = $signed({n_err[ERR_W-1], n_err})
                  - $signed({r_prev_err[idx][ERR_W-1], r_prev_err[idx]});

    // update the addressed channel as the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_err_sum[k]  <= '0;
                r_prev_err[k] <= '0;
            end
        end else if (i_en && r_vld && in_range) begin
            if (r_clr) begin
                r_err_sum[idx]  <= '0;
                r_prev_err[idx] <= '0;
            end else begin
                r_err_sum[idx]  <= n_acc;
                r_prev_err[idx] <= n_err;
            end
        end
    end

    // stage register towards the multipliers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= r_vld;
        end
        if (i_en) begin
            r_word.zero <= r_clr || !in_range;
            r_word.ch   <= r_ch;
            r_word.err  <= n_err;
            r_word.acc  <= n_acc;
            r_word.diff <= n_diff;
        end
    end

    assign o_word = r_word;

endmodule

// ===== src/pisc_mult.sv =====
`timescale 1ns / 1ps

module pisc_mult (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  pisc_pkg::t_cfg        i_cfg,
    input  pisc_pkg::t_err_word   i_word,
    output pisc_pkg::t_prod_word  o_word
);
    import pisc_pkg::*;

    logic signed [PROD_P_W-1:0] n_prod_p;
    logic signed [PROD_I_W-1:0] n_prod_i;
    logic signed [PROD_D_W-1:0] n_prod_d;
    t_prod_word                 r_word;

    // three gain products side by side
    assign n_prod_p = PROD_P_W'(i_cfg.gain_p) * PROD_P_W'(i_word.err);
    assign n_prod_i = PROD_I_W'(i_cfg.gain_i) * PROD_I_W'(i_word.acc);
    assign n_prod_d = PROD_D_W'(i_cfg.gain_d) * PROD_D_W'(i_word.diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= i_word.vld;
        end
        if (i_en) begin
            r_word.zero   <= i_word.zero;
            r_word.ch     <= i_word.ch;
            r_word.prod_p <= n_prod_p;
            r_word.prod_i <= n_prod_i;
            r_word.prod_d <= n_prod_d;
        end
    end

    assign o_word = r_word;

endmodule

// ===== src/pisc_sat.sv =====
`timescale 1ns / 1ps

module pisc_sat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  pisc_pkg::t_cfg                i_cfg,
    input  pisc_pkg::t_prod_word          i_word,
    output logic                          o_vld,
    output logic [pisc_pkg::CH_W-1:0]     o_ch,
    output logic [pisc_pkg::DRIVE_W-1:0]  o_drive,
    output logic                          o_sat
);
    import pisc_pkg::*;

    logic signed [TOTAL_W-1:0]   total;
    logic signed [SHIFTED_W-1:0] shifted;
    logic signed [SHIFTED_W-1:0] lim_pos;
    logic signed [SHIFTED_W-1:0] lim_neg;
    logic [DRIVE_W-1:0]          n_drive;
    logic                        n_sat;

    logic                        r_vld;
    logic [CH_W-1:0]             r_ch;
    logic [DRIVE_W-1:0]          r_drive;
    logic                        r_sat;

    // sum the terms and drop the fraction, rounding down
    assign total   = TOTAL_W'(i_word.prod_p) + TOTAL_W'(i_word.prod_i)
                   + TOTAL_W'(i_word.prod_d);
    assign shifted = total[TOTAL_W-1:SHIFT];
    assign lim_pos = $signed({{(SHIFTED_W-LIM_W){1'b0}}, i_cfg.out_lim});
    assign lim_neg = -lim_pos;

    // clamp the drive, zero it for clear and unused channels
    always_comb begin
        n_drive = shifted[DRIVE_W-1:0];
        n_sat   = 1'b0;
        if (i_word.zero) begin
            n_drive = '0;
        end else if (shifted > lim_pos) begin
            n_drive = lim_pos[DRIVE_W-1:0];
            n_sat   = 1'b1;
        end else if (shifted < lim_neg) begin
            n_drive = lim_neg[DRIVE_W-1:0];
            n_sat   = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_word.vld;
        end
        if (i_en) begin
            r_ch    <= i_word.ch;
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

    assign o_vld   = r_vld;
    assign o_ch    = r_ch;
    assign o_drive = r_drive;
    assign o_sat   = r_sat;

endmodule

// ===== src/pid_integral_separation_clamp_core.sv =====
`timescale 1ns / 1ps
// Channel    | Direction | Handshake                       | Payload
// s_axis     | in        | i_s_axis_tvalid/o_s_axis_tready | tuser: req_type; tdata: channel,
//            |           |                                 |   setpoint, measured_angle
// m_axis     | out       | o_m_axis_tvalid/i_m_axis_tready | tuser: saturated; tdata: channel_out,
//            |           |                                 |   drive
// cfg        | in        | i_cfg_we                        | i_cfg_idx, i_cfg_data
//
// One word accepted per cycle while the output is not stalled, one result per word. Stages:
// input register, state stage (per-channel integral read, update and write as the word moves
// on), multiply stage, output register. The per-channel state update in the state stage sets
// the one-word-per-cycle rate, also for the same channel twice in a row.
// Synchronous active-low reset clears valids and channel state, config registers to defaults.
// A stall on the output freezes every stage; input is taken whenever the output
// register is empty or being emptied.

module pid_integral_separation_clamp_core #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [2:0] channel, [33:3] setpoint, [64:34] measured_angle, [71:65] zero
    input  logic [pisc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] req_type
    input  logic                                i_s_axis_tuser,
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [2:0] channel_out, [18:3] drive, [23:19] zero
    output logic [pisc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] saturated
    output logic                                o_m_axis_tuser,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pisc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pisc_pkg::*;

    localparam int TGT_LO  = CH_W;
    localparam int MEAS_LO = CH_W + ANGLE_W;

    t_cfg               r_cfg;
    logic               en;
    t_err_word          err_word;
    t_prod_word         prod_word;
    logic               out_vld;
    logic [CH_W-1:0]    out_ch;
    logic [DRIVE_W-1:0] out_drive;
    logic               out_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p  <= '0;
            r_cfg.gain_i  <= '0;
            r_cfg.gain_d  <= '0;
            r_cfg.int_lim <= INT_LIM_RESET;
            r_cfg.sep_thr <= SEP_THR_RESET;
            r_cfg.out_lim <= OUT_LIM_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:  r_cfg.gain_p  <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_I:  r_cfg.gain_i  <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_D:  r_cfg.gain_d  <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_INT_LIM: r_cfg.int_lim <= i_cfg_data[LIM_W-1:0];
                CFG_SEP_THR: r_cfg.sep_thr <= i_cfg_data[LIM_W-1:0];
                CFG_OUT_LIM: r_cfg.out_lim <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless the output word is held
    assign en              = !out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    pisc_state #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_clr   (i_s_axis_tuser),
        .i_ch    (i_s_axis_tdata[CH_W-1:0]),
        .i_tgt   (i_s_axis_tdata[TGT_LO+ANGLE_W-1:TGT_LO]),
        .i_meas  (i_s_axis_tdata[MEAS_LO+ANGLE_W-1:MEAS_LO]),
        .i_cfg   (r_cfg),
        .o_word  (err_word)
    );

    pisc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_word  (err_word),
        .o_word  (prod_word)
    );

    pisc_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_word  (prod_word),
        .o_vld   (out_vld),
        .o_ch    (out_ch),
        .o_drive (out_drive),
        .o_sat   (out_sat)
    );

    assign o_m_axis_tvalid = out_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-DRIVE_W-CH_W){1'b0}}, out_drive, out_ch};
    assign o_m_axis_tuser  = out_sat;

endmodule

// ===== src/pisc_checker.sv =====
`timescale 1ns / 1ps

module pisc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [pisc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                                o_m_axis_tuser
);
    import pisc_pkg::*;

    // held result word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // clamped drive never reaches the most negative code
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[CH_W+DRIVE_W-1:CH_W] != 16'h8000)
        else $error("drive outside the clamp range");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // input is taken whenever the output register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output");

endmodule

bind pid_integral_separation_clamp_core pisc_checker u_pisc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pisc_pkg::*;

    localparam int NCH         = 8;
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 120;
    localparam int ANG_MAX     = 1073741823;
    localparam int ANG_MIN     = -1073741824;

    typedef struct {
        bit       clr;
        bit [2:0] ch;
        int       tgt;
        int       meas;
    } step_t;

    typedef struct {
        bit [2:0]           ch;
        logic signed [15:0] drive;
        bit                 sat;
    } drive_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_t;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   hold_req = 1'b0;

    // controller copy: registers and per-channel state
    shortint kp = 0, ki = 0, kd = 0;
    int      int_lim = 2000, sep_thr = 200, out_lim = 1000;
    longint  integ_sum   [NCH] = '{default: 0};
    longint  prior_error [NCH] = '{default: 0};

    step_t  step_queue [$];
    drive_t drive_expected [$];
    int     n_queued   = 0;
    int     n_accepted = 0;
    int     n_errors   = 0;
    int     cycles     = 0;

    pid_integral_separation_clamp_core #(
        .NUM_CHANNELS (NCH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // work out the drive for one word and advance the channel state
    function automatic drive_t pid_predict(step_t s);
        drive_t r;
        longint err, mag, acc, total, drv;
        r.ch    = s.ch;
        r.drive = '0;
        r.sat   = 1'b0;
        if (s.clr) begin
            integ_sum[s.ch]   = 0;
            prior_error[s.ch] = 0;
        end else begin
            err = longint'(s.tgt) - longint'(s.meas);
            mag = (err < 0) ? -err : err;
            acc = integ_sum[s.ch];
            // integrate only small errors, then bound the sum
            if (mag <= sep_thr)
                acc += err;
            if (acc > int_lim)
                acc = int_lim;
            else if (acc < -int_lim)
                acc = -int_lim;
            integ_sum[s.ch] = acc;
            total = longint'(kp) * err + longint'(ki) * acc
                  + longint'(kd) * (err - prior_error[s.ch]);
            prior_error[s.ch] = err;
            drv = total >>> 8;
            if (drv > out_lim) begin
                drv   = out_lim;
                r.sat = 1'b1;
            end else if (drv < -out_lim) begin
                drv   = -out_lim;
                r.sat = 1'b1;
            end
            r.drive = drv[15:0];
        end
        return r;
    endfunction

    // sender: bursts of words with random gaps in between
    step_t cur_step;
    int    burst_left = 0;
    int    gap_left   = 0;

    always @(posedge i_clk) begin
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                drive_expected.push_back(pid_predict(cur_step));
                n_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (burst_left > 0) begin
                    if (step_queue.size() != 0) begin
                        cur_step = step_queue.pop_front();
                        s_tdata  <= {7'b0, cur_step.meas[30:0], cur_step.tgt[30:0],
                                     cur_step.ch};
                        s_tuser  <= cur_step.clr;
                        nxt_valid = 1'b1;
                        burst_left--;
                    end
                end else begin
                    gap_left--;
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    rx_mode_t   rx_mode   = RX_OPEN;
    int         rx_left   = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic [7:0] rx_mask   = 8'hff;

    always @(posedge i_clk) begin
        logic nxt_ready;
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
            rx_mask = 8'($urandom_range(1, 255));
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   nxt_ready = 1'b1;
            RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
            default:   nxt_ready = rx_mask[rx_left % 8];
        endcase
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end
        m_tready <= nxt_ready;
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        drive_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected result word, channel %0d drive %0d",
                         $time, m_tdata[2:0], $signed(m_tdata[18:3]));
                n_errors++;
            end else begin
                want = drive_expected.pop_front();
                if (m_tdata[2:0] !== want.ch) begin
                    $display("%0t: channel expected %0d got %0d",
                             $time, want.ch, m_tdata[2:0]);
                    n_errors++;
                end
                if (m_tdata[18:3] !== want.drive) begin
                    $display("%0t: drive on channel %0d expected %0d got %0d",
                             $time, want.ch, want.drive, $signed(m_tdata[18:3]));
                    n_errors++;
                end
                if (m_tuser !== want.sat) begin
                    $display("%0t: saturated on channel %0d expected %0d got %0d",
                             $time, want.ch, want.sat, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("pid_integral_separation_clamp_core regression: fail");
            $finish;
        end
    end

    task automatic add_step(bit clr, bit [2:0] ch, int tgt, int meas);
        step_t s;
        s.clr  = clr;
        s.ch   = ch;
        s.tgt  = tgt;
        s.meas = meas;
        step_queue.push_back(s);
        n_queued++;
    endtask

    // hold until every word is in and every result is out
    task automatic wait_idle();
        while (n_accepted != n_queued || drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    // one register write per cycle; call just after a rising edge
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:  kp = val;
            CFG_GAIN_I:  ki = val;
            CFG_GAIN_D:  kd = val;
            CFG_INT_LIM: int_lim = val[14:0];
            CFG_SEP_THR: sep_thr = val[14:0];
            CFG_OUT_LIM: out_lim = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(shortint p, shortint ig, shortint d, int il, int st, int ol);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, ig);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_INT_LIM, 16'(il));
        write_reg(CFG_SEP_THR, 16'(st));
        write_reg(CFG_OUT_LIM, 16'(ol));
        cfg_we <= 1'b0;
    endtask

    function automatic shortint random_gain();
        case ($urandom_range(0, 2))
            0:       return shortint'($urandom_range(0, 65535));
            1:       return shortint'(int'($urandom_range(0, 1024)) - 512);
            default: return shortint'(int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    function automatic int random_limit();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32767)
                                           : $urandom_range(0, 3000);
    endfunction

    // mostly errors near the separation band so the integral gets exercised
    function automatic step_t random_step();
        step_t s;
        int    span, base;
        span   = (sep_thr > 0 ? sep_thr : 8) * 3;
        s.clr  = 1'b0;
        s.ch   = 3'($urandom_range(0, NCH - 1));
        s.tgt  = int'($urandom) >>> 1;
        s.meas = int'($urandom) >>> 1;
        base   = int'($urandom) >>> 2;
        case ($urandom_range(0, 9))
            0: s.clr = 1'b1;
            1, 2: ;
            3: begin
                s.tgt  = int'($urandom_range(0, 2000)) - 1000;
                s.meas = int'($urandom_range(0, 2000)) - 1000;
            end
            4: begin
                s.meas = base;
                s.tgt  = base + ($urandom_range(0, 1) ? sep_thr : -sep_thr)
                       + int'($urandom_range(0, 1));
            end
            default: begin
                s.meas = base;
                s.tgt  = base + int'($urandom_range(0, 2 * span)) - span;
            end
        endcase
        return s;
    endfunction

    initial begin
        step_t s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at their reset values: zero gains give zero drive
        add_step(1'b0, 3'd0, 500, 0);
        add_step(1'b1, 3'd0, 0, 0);
        add_step(1'b0, 3'd6, -300, 0);
        wait_idle();

        set_regs(256, 32, 128, 500, 100, 20000);
        // angle extremes in both directions, then clear
        add_step(1'b0, 3'd0, ANG_MAX, ANG_MIN);
        add_step(1'b0, 3'd0, ANG_MIN, ANG_MAX);
        add_step(1'b1, 3'd0, ANG_MAX, ANG_MIN);
        add_step(1'b0, 3'd1, 0, 0);
        // error at the separation threshold, one past it, and negative
        add_step(1'b0, 3'd1, 100, 0);
        add_step(1'b0, 3'd1, -101, 0);
        add_step(1'b0, 3'd1, -100, 0);
        add_step(1'b0, 3'd7, ANG_MAX, ANG_MAX);
        add_step(1'b0, 3'd3, -5, 5);
        // wind the integral up to its limit, back to back on one channel
        repeat (7) add_step(1'b0, 3'd4, 95, 0);
        add_step(1'b1, 3'd2, 0, 0);
        add_step(1'b0, 3'd2, ANG_MIN + 10, ANG_MIN);
        wait_idle();

        // lowered integral limit reclamps; zero output limit saturates any nonzero drive
        set_regs(256, 32, 128, 100, 100, 0);
        add_step(1'b0, 3'd4, 1000, 0);
        add_step(1'b0, 3'd4, 0, 0);
        add_step(1'b1, 3'd5, 0, 0);
        add_step(1'b0, 3'd5, 7, 7);
        wait_idle();

        // random phases over several register settings, extremes first
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       set_regs(32767, -32768, 32767, 32767, 32767, 32767);
                1:       set_regs(-32768, 32767, -32768, 0, 0, 0);
                2:       set_regs(384, 16, 256, 2000, 200, 1000);
                default: set_regs(random_gain(), random_gain(), random_gain(),
                                  random_limit(), random_limit(), random_limit());
            endcase
            if (ph == 2)
                hold_req <= 1'b1;
            repeat (PHASE_WORDS) begin
                s = random_step();
                add_step(s.clr, s.ch, s.tgt, s.meas);
            end
            wait_idle();
        end

        repeat (4 * LATENCY) @(posedge i_clk);
        if (n_errors == 0 && drive_expected.size() == 0)
            $display("pid_integral_separation_clamp_core regression: pass");
        else
            $display("pid_integral_separation_clamp_core regression: fail");
        $finish;
    end

endmodule
